// ----- hdl/rwse_pkg.sv -----
// Shared constants, word types and verdict codes of the replay window checker.
package rwse_pkg;

  localparam int SEQ_LOW_W   = 24;
  localparam int WINDOW_BITS = 32;
  localparam int FULL_SEQ_W  = 64;
  localparam int WIN_IDX_W   = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam int MAG_EXT_W   = SEQ_LOW_W + 8;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT = 3'd0,
    VERDICT_WRAP   = 3'd1,
    VERDICT_OLD    = 3'd2,
    VERDICT_DUP    = 3'd3,
    VERDICT_AUTH   = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [SEQ_LOW_W-1:0] seq_low;
    logic                 auth_ok;
  } pkt_word_t;

  typedef struct packed {
    verdict_t              verdict;
    logic [FULL_SEQ_W-1:0] full_seq;
    logic                  window_moved;
  } res_word_t;

  typedef struct packed {
    logic                   write;
    logic [FULL_SEQ_W-1:0]  highest_seq;
    logic [WINDOW_BITS-1:0] seen_mask;
  } win_update_t;

endpackage

// ----- hdl/rwse_judge.sv -----
// Sequence extension, replay verdict and next window state for one packet word.
module rwse_judge (
  input  rwse_pkg::pkt_word_t                word,
  input  logic [rwse_pkg::FULL_SEQ_W-1:0]    highest_seq,
  input  logic [rwse_pkg::WINDOW_BITS-1:0]   seen_mask,
  output rwse_pkg::res_word_t                result,
  output rwse_pkg::win_update_t              update
);
  import rwse_pkg::*;

  logic [SEQ_LOW_W-1:0]   diff_raw;
  logic [SEQ_LOW_W-1:0]   back_mag;
  logic [FULL_SEQ_W-1:0]  diff_ext;
  logic [FULL_SEQ_W-1:0]  full;
  logic                   ahead;
  logic                   behind;
  logic                   too_old;
  logic                   far_ahead;
  logic                   wrap;
  logic                   dup;
  logic [WIN_IDX_W-1:0]   bit_idx;
  logic [WINDOW_BITS-1:0] shifted;
  verdict_t               verdict;

  always_comb begin
    diff_raw  = word.seq_low - highest_seq[SEQ_LOW_W-1:0];
    diff_ext  = {{(FULL_SEQ_W-SEQ_LOW_W){diff_raw[SEQ_LOW_W-1]}}, diff_raw};
    full      = highest_seq + diff_ext;
    behind    = diff_raw[SEQ_LOW_W-1];
    ahead     = !behind && (diff_raw != '0);
    back_mag  = '0 - diff_raw;
    too_old   = behind &&
                ({8'd0, back_mag} >= MAG_EXT_W'(WINDOW_BITS));
    far_ahead = {8'd0, diff_raw} >= MAG_EXT_W'(WINDOW_BITS);
    wrap      = ahead && (full < highest_seq);
    bit_idx   = back_mag[WIN_IDX_W-1:0];
    dup       = !ahead && !too_old && seen_mask[bit_idx];

    if (wrap) begin
      verdict = VERDICT_WRAP;
    end else if (too_old) begin
      verdict = VERDICT_OLD;
    end else if (dup) begin
      verdict = VERDICT_DUP;
    end else if (!word.auth_ok) begin
      verdict = VERDICT_AUTH;
    end else begin
      verdict = VERDICT_ACCEPT;
    end

    shifted = far_ahead ? '0 : (seen_mask << diff_raw[WIN_IDX_W-1:0]);

    update.write = (verdict == VERDICT_ACCEPT);
    if (ahead) begin
      update.highest_seq = full;
      update.seen_mask   = shifted | WINDOW_BITS'(1);
    end else begin
      update.highest_seq = highest_seq;
      update.seen_mask   = seen_mask | (WINDOW_BITS'(1) << bit_idx);
    end

    result.verdict      = verdict;
    result.full_seq     = full;
    result.window_moved = (verdict == VERDICT_ACCEPT) && ahead;
  end

endmodule

// ----- hdl/replay_window_seq_extend.sv -----
// Top level of the receive-side anti-replay checker with sequence extension.
//
// The pkt channel carries one word per received packet: the low 24 bits of
// its transmit sequence and a flag telling whether authentication passed.
// The res channel returns one word per packet word: the verdict (accepted,
// wraparound, too old, duplicate or authentication failed), the sequence
// expanded to 64 bits against the highest accepted sequence, and a flag set
// when an accepted packet advanced the window.
// A packet word is taken into an input register; from there a single pass
// of add, compare and barrel shift produces the verdict, which is loaded
// into the result register when the held word advances, while an accepted
// packet updates the window state at the same edge. The result register
// then offers the result word. One word is accepted per cycle while the
// receiver takes results, with no gaps, since the next packet reads the
// window state written by the previous one directly.
// When the receiver stalls, the result register holds its word and the input
// register may still take one more packet word; after that pkt_ready drops.
// Reset clears both registers' valid flags, the highest sequence and the
// window mask.
module replay_window_seq_extend (
  input  logic                clk,
  input  logic                rst,
  input  logic                pkt_valid,
  output logic                pkt_ready,
  input  rwse_pkg::pkt_word_t pkt,
  output logic                res_valid,
  input  logic                res_ready,
  output rwse_pkg::res_word_t res
);
  import rwse_pkg::*;

  logic                   s1_valid;
  pkt_word_t              s1_word;
  logic [FULL_SEQ_W-1:0]  highest_seq;
  logic [WINDOW_BITS-1:0] seen_mask;
  res_word_t              judged;
  win_update_t            update;
  logic                   advance;

  // The judge sees the held packet word against the current window state.
  rwse_judge u_judge (
    .word        (s1_word),
    .highest_seq (highest_seq),
    .seen_mask   (seen_mask),
    .result      (judged),
    .update      (update)
  );

  // The held word moves on whenever the result register is free or drains.
  assign advance   = s1_valid && (!res_valid || res_ready);
  assign pkt_ready = !s1_valid || !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      res_valid   <= 1'b0;
      highest_seq <= '0;
      seen_mask   <= '0;
    end else begin
      if (pkt_valid && pkt_ready) begin
        s1_valid <= 1'b1;
        s1_word  <= pkt;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        res_valid <= 1'b1;
        res       <= judged;
        // Dropped packets leave the window untouched.
        if (update.write) begin
          highest_seq <= update.highest_seq;
          seen_mask   <= update.seen_mask;
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/rwse_checker.sv -----
// Port-level checks of the replay window checker and their binding.
module rwse_checker (
  input logic                clk,
  input logic                rst,
  input logic                pkt_valid,
  input logic                pkt_ready,
  input rwse_pkg::pkt_word_t pkt,
  input logic                res_valid,
  input logic                res_ready,
  input rwse_pkg::res_word_t res
);
  import rwse_pkg::*;

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // Only an accepted packet can move the window.
  a_moved_accept: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.window_moved |-> res.verdict == VERDICT_ACCEPT)
    else $error("window moved on a dropped packet");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // Nothing is offered unless a packet word was taken before.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pkt_valid && pkt_ready, 2) || $past(!pkt_ready))
    else $error("result word without a packet word");

endmodule

bind replay_window_seq_extend rwse_checker u_rwse_checker (.*);
